### hdl/twcc_pkg.sv
// Shared types and constants for the transport-wide feedback parser.
package twcc_pkg;

  localparam int MAX_STATUSES = 4096;
  localparam int ADDR_W       = $clog2(MAX_STATUSES);
  localparam int ENTRY_W      = $clog2(MAX_STATUSES + 1);

  localparam logic [1:0] SYM_NONE     = 2'd0;
  localparam logic [1:0] SYM_SMALL    = 2'd1;
  localparam logic [1:0] SYM_LARGE    = 2'd2;

  localparam logic signed [16:0] TIME_UNIT_US  = 17'sd64000;
  localparam logic signed [16:0] DELTA_UNIT_US = 17'sd250;

  typedef enum logic [2:0] {
    PH_HEAD, PH_CHUNK, PH_DELTA, PH_DONE, PH_ZERO, PH_MANY
  } phase_e;

  typedef enum logic [3:0] {
    ST_IN, ST_CHUNK, ST_FILL, ST_BEGIN, ST_BEGIN2, ST_SCAN, ST_SCAN_EV,
    ST_RPT, ST_RPT2, ST_FIN, ST_END
  } state_e;

  typedef enum logic [2:0] {
    END_OK, END_SHORT_HEADER, END_ZERO_COUNT, END_TRUNC_CHUNK,
    END_TRUNC_DELTA, END_TOO_MANY
  } end_code_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [1:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

### hdl/twcc_status_ram.sv
// Status store: one write port and one registered read port.
module twcc_status_ram (
  input  logic               clk_i,
  input  twcc_pkg::ram_req_t req_i,
  output logic [1:0]         rdata_o
);
  import twcc_pkg::*;

  logic [1:0] mem [MAX_STATUSES];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule

### hdl/twcc_feedback_parser_unit.sv
// Top level of the transport-wide feedback parser: sequencer, shared multiplier, output register.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o  | payload_byte_i, last_byte_i
//  out     | output    | out_valid_o/out_ready_i| result_kind_o .. end_code_o
//
// A header, chunk-high or delta-high byte passes through ST_FIN. A chunk writes its statuses
// one per cycle through the single store write port; the chunk that completes the
// store, or an oversized run, then starts the delta scan, which skips unreceived entries.
// A delta passes through ST_RPT and ST_RPT2 and then skips unreceived entries, using
// the registered store read and the shared multiplier. A final byte adds the end request.
// The store needs no clearing pass: a fill count marks entries not yet written.
// The output register holds a request while the parser runs on; a second request stalls it.
module twcc_feedback_parser_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          payload_byte_i,
  input  logic                last_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                result_kind_o,
  output logic [15:0]         seq_no_o,
  output logic [1:0]          status_kind_o,
  output logic signed [23:0]  delta_us_o,
  output logic signed [41:0]  arrival_time_o,
  output logic                time_valid_o,
  output logic [2:0]          end_code_o
);
  import twcc_pkg::*;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [2:0]  bc_q, bc_d;
  logic [15:0] base_q, base_d, count_q, count_d;
  logic [23:0] ref_q, ref_d;
  logic [7:0]  chb_q, chb_d, dhb_q, dhb_d, byte_q, byte_d;
  logic        last_q, last_d;
  logic [ENTRY_W-1:0] entry_q, entry_d, fill_q, fill_d;
  logic signed [41:0] running_q, running_d, prod_q, prod_d;
  logic        chain_q, chain_d;
  logic        rle_q, rle_d, two_q, two_d;
  logic [13:0] vec_q, vec_d;
  logic [12:0] rem_q, rem_d;
  logic [1:0]  sym_q, sym_d, cur_q, cur_d;
  logic signed [15:0] raw_q, raw_d;

  logic        ov_q, ov_d, okind_q, okind_d, otv_q, otv_d;
  logic [15:0] oseq_q, oseq_d;
  logic [1:0]  ost_q, ost_d;
  logic signed [23:0] odelta_q, odelta_d;
  logic signed [41:0] oarr_q, oarr_d;
  logic [2:0]  ocode_q, ocode_d;

  ram_req_t    ram_req;
  logic [1:0]  ram_rdata;

  logic signed [23:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [40:0] mul_p;
  logic        out_free;
  logic [15:0] hdr;
  logic [1:0]  rd_sym;
  logic signed [41:0] sum;

  twcc_status_ram u_store (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assign mul_p    = mul_a * mul_b;
  assign out_free = !ov_q || out_ready_i;
  assign hdr      = {chb_q, byte_q};
  assign rd_sym   = (entry_q < fill_q) ? ram_rdata : SYM_NONE;
  assign sum      = running_q + prod_q;

  always_comb begin
    state_d = state_q;  phase_d = phase_q;  bc_d = bc_q;
    base_d = base_q;  count_d = count_q;  ref_d = ref_q;
    chb_d = chb_q;  dhb_d = dhb_q;  byte_d = byte_q;  last_d = last_q;
    entry_d = entry_q;  fill_d = fill_q;  running_d = running_q;  prod_d = prod_q;
    chain_d = chain_q;  rle_d = rle_q;  two_d = two_q;  vec_d = vec_q;
    rem_d = rem_q;  sym_d = sym_q;  cur_d = cur_q;  raw_d = raw_q;
    ov_d = ov_q && !out_ready_i;
    okind_d = okind_q;  otv_d = otv_q;  oseq_d = oseq_q;  ost_d = ost_q;
    odelta_d = odelta_q;  oarr_d = oarr_q;  ocode_d = ocode_q;
    ram_req = '0;
    ram_req.waddr = entry_q[ADDR_W-1:0];
    ram_req.raddr = entry_q[ADDR_W-1:0];
    mul_a = {{8{raw_q[15]}}, raw_q};
    mul_b = DELTA_UNIT_US;
    in_ready_o = 1'b0;

    case (state_q)
      ST_IN: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          byte_d  = payload_byte_i;
          last_d  = last_byte_i;
          state_d = ST_FIN;
          case (phase_q)
            PH_HEAD: begin
              bc_d = bc_q + 3'd1;
              case (bc_q)
                3'd0: base_d = {payload_byte_i, 8'h00};
                3'd1: base_d[7:0] = payload_byte_i;
                3'd2: count_d = {payload_byte_i, 8'h00};
                3'd3: count_d[7:0] = payload_byte_i;
                3'd4: ref_d = {payload_byte_i, 16'h0000};
                3'd5: ref_d[15:8] = payload_byte_i;
                3'd6: ref_d[7:0] = payload_byte_i;
                default: begin
                  bc_d = 3'd0;
                  if (count_q == 16'd0) begin
                    phase_d = PH_ZERO;
                  end else if ({1'b0, count_q} > 17'(MAX_STATUSES)) begin
                    phase_d = PH_MANY;
                  end else begin
                    entry_d = '0;
                    fill_d  = '0;
                    phase_d = PH_CHUNK;
                  end
                end
              endcase
            end
            PH_CHUNK: begin
              if (bc_q == 3'd0) begin
                chb_d = payload_byte_i;
                bc_d  = 3'd1;
              end else begin
                bc_d    = 3'd0;
                state_d = ST_CHUNK;
              end
            end
            PH_DELTA: begin
              if (cur_q == SYM_SMALL) begin
                raw_d   = {8'h00, payload_byte_i};
                state_d = ST_RPT;
              end else if (bc_q == 3'd0) begin
                dhb_d = payload_byte_i;
                bc_d  = 3'd1;
              end else begin
                raw_d   = {dhb_q, payload_byte_i};
                state_d = ST_RPT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CHUNK: begin
        state_d = ST_FILL;
        vec_d   = hdr[13:0];
        sym_d   = hdr[14:13];
        if (!hdr[15]) begin
          rle_d = 1'b1;
          rem_d = hdr[12:0];
          if ((count_q - 16'(entry_q)) < {3'b000, hdr[12:0]}) begin
            state_d = ST_BEGIN;
          end
        end else begin
          rle_d = 1'b0;
          two_d = hdr[14];
          rem_d = hdr[14] ? 13'd7 : 13'd14;
        end
      end
      ST_FILL: begin
        if (rem_q != 13'd0 && (rle_q || 16'(entry_q) < count_q)) begin
          ram_req.we    = 1'b1;
          ram_req.wdata = rle_q ? sym_q : (two_q ? vec_q[13:12] : {1'b0, vec_q[13]});
          vec_d   = two_q ? {vec_q[11:0], 2'b00} : {vec_q[12:0], 1'b0};
          entry_d = entry_q + 1'b1;
          fill_d  = entry_q + 1'b1;
          rem_d   = rem_q - 13'd1;
        end else if (16'(entry_q) >= count_q) begin
          state_d = ST_BEGIN;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_BEGIN: begin
        mul_a   = ref_q;
        mul_b   = TIME_UNIT_US;
        prod_d  = {mul_p[40], mul_p};
        state_d = ST_BEGIN2;
      end
      ST_BEGIN2: begin
        running_d = prod_q;
        chain_d   = 1'b1;
        entry_d   = '0;
        bc_d      = 3'd0;
        phase_d   = PH_DELTA;
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        if (16'(entry_q) < count_q) begin
          ram_req.re = 1'b1;
          state_d    = ST_SCAN_EV;
        end else begin
          phase_d = PH_DONE;
          state_d = ST_FIN;
        end
      end
      ST_SCAN_EV: begin
        if (rd_sym == SYM_SMALL || rd_sym == SYM_LARGE) begin
          cur_d   = rd_sym;
          state_d = ST_FIN;
        end else begin
          chain_d = 1'b0;
          entry_d = entry_q + 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_RPT: begin
        prod_d  = {mul_p[40], mul_p};
        state_d = ST_RPT2;
      end
      ST_RPT2: begin
        if (out_free) begin
          ov_d     = 1'b1;
          okind_d  = 1'b0;
          oseq_d   = base_q + 16'(entry_q);
          ost_d    = cur_q;
          odelta_d = prod_q[23:0];
          ocode_d  = END_OK;
          otv_d    = chain_q;
          oarr_d   = chain_q ? sum : '0;
          if (chain_q) begin
            running_d = sum;
          end
          entry_d = entry_q + 1'b1;
          bc_d    = 3'd0;
          state_d = ST_SCAN;
        end
      end
      ST_FIN: begin
        state_d = last_q ? ST_END : ST_IN;
      end
      ST_END: begin
        if (out_free) begin
          ov_d     = 1'b1;
          okind_d  = 1'b1;
          oseq_d   = '0;
          ost_d    = SYM_NONE;
          odelta_d = '0;
          oarr_d   = '0;
          otv_d    = 1'b0;
          case (phase_q)
            PH_HEAD:  ocode_d = END_SHORT_HEADER;
            PH_CHUNK: ocode_d = END_TRUNC_CHUNK;
            PH_DELTA: ocode_d = END_TRUNC_DELTA;
            PH_ZERO:  ocode_d = END_ZERO_COUNT;
            PH_MANY:  ocode_d = END_TOO_MANY;
            default:  ocode_d = END_OK;
          endcase
          phase_d = PH_HEAD;
          bc_d    = 3'd0;
          state_d = ST_IN;
        end
      end
      default: state_d = ST_IN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IN;  phase_q <= PH_HEAD;  bc_q <= '0;
      base_q <= '0;  count_q <= '0;  ref_q <= '0;  chb_q <= '0;  dhb_q <= '0;
      entry_q <= '0;  fill_q <= '0;  running_q <= '0;  chain_q <= 1'b1;
      last_q <= 1'b0;  ov_q <= 1'b0;
    end else begin
      state_q <= state_d;  phase_q <= phase_d;  bc_q <= bc_d;
      base_q <= base_d;  count_q <= count_d;  ref_q <= ref_d;  chb_q <= chb_d;
      dhb_q <= dhb_d;  entry_q <= entry_d;  fill_q <= fill_d;
      running_q <= running_d;  chain_q <= chain_d;  last_q <= last_d;  ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;  prod_q <= prod_d;  rle_q <= rle_d;  two_q <= two_d;
    vec_q <= vec_d;  rem_q <= rem_d;  sym_q <= sym_d;  cur_q <= cur_d;  raw_q <= raw_d;
    okind_q <= okind_d;  otv_q <= otv_d;  oseq_q <= oseq_d;  ost_q <= ost_d;
    odelta_q <= odelta_d;  oarr_q <= oarr_d;  ocode_q <= ocode_d;
  end

  assign out_valid_o    = ov_q;
  assign result_kind_o  = okind_q;
  assign seq_no_o       = oseq_q;
  assign status_kind_o  = ost_q;
  assign delta_us_o     = odelta_q;
  assign arrival_time_o = oarr_q;
  assign time_valid_o   = otv_q;
  assign end_code_o     = ocode_q;

  // Chunk writes go strictly in order, so the fill count tracks the write pointer.
  a_fill_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.we |-> (entry_q == fill_q))
    else $error("status write out of order");

  a_delta_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DELTA) |-> (16'(entry_q) <= count_q))
    else $error("entry index beyond status count");

  a_end_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_END && out_free) |=> (phase_q == PH_HEAD && out_valid_o && result_kind_o))
    else $error("end request not issued");

endmodule
